// File: hw/rtl/wdft_pkg.sv
// Shared types, constants and ROM builders of the windowed DFT.
`default_nettype none
package wdft_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int SAMPLE_W   = 16;
    localparam int BIN_W      = 32;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;

    typedef logic [MAX_POINTS*SAMPLE_W-1:0] rom_t;

    typedef struct packed {
        logic signed [63:0] co;
        logic signed [63:0] si;
    } trig_t;

    typedef struct packed {
        longint unsigned quot;
        longint unsigned rem;
    } divmod_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] x;
        logic [IDX_W-1:0]           n;
        logic [IDX_W-1:0]           m;
    } cell_bus_t;

    // Unsigned quotient and remainder by shift and subtract; used only at elaboration.
    function automatic divmod_t udivmod(longint unsigned num, longint unsigned den);
        divmod_t res;
        res.quot = '0;
        res.rem  = '0;
        for (int i = 63; i >= 0; i--)
        begin
            res.rem = {res.rem[62:0], num[i]};
            if (res.rem >= den)
            begin
                res.rem     = res.rem - den;
                res.quot[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // Q30 cosine and sine of 2*pi*p/q from integer series; used only at elaboration.
    function automatic trig_t trig30(longint unsigned p_in, longint unsigned q);
        trig_t           res;
        divmod_t         dm;
        longint unsigned p;
        longint unsigned qd;
        longint unsigned r;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned ts;
        longint unsigned tc;
        longint          s;
        longint          c;
        longint          smag;
        longint          cmag;
        dm = udivmod(p_in, q);
        p  = dm.rem;
        dm = udivmod(4 * p, q);
        qd = dm.quot;
        r  = dm.rem;
        dm = udivmod(r * PI_Q30, 2 * q);
        a  = dm.quot;
        a2 = (a * a) >> 30;
        s  = longint'(a);
        ts = a;
        c  = ONE_Q30;
        tc = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++) begin
            dm = udivmod((ts * a2) >> 30, longint'((2 * k) * (2 * k + 1)));
            ts = dm.quot;
            dm = udivmod((tc * a2) >> 30, longint'((2 * k - 1) * (2 * k)));
            tc = dm.quot;
            if (k[0]) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        smag = (s < 0) ? 0 : ((s > ONE_Q30) ? ONE_Q30 : s);
        cmag = (c < 0) ? 0 : ((c > ONE_Q30) ? ONE_Q30 : c);
        case (qd[1:0])
            2'd0:    begin res.si = smag;  res.co = cmag;  end
            2'd1:    begin res.si = cmag;  res.co = -smag; end
            2'd2:    begin res.si = -smag; res.co = -cmag; end
            default: begin res.si = -cmag; res.co = smag;  end
        endcase
        return res;
    endfunction

    // Q30 to Q1.15, rounding half away from zero and saturating the magnitude.
    function automatic logic signed [SAMPLE_W-1:0] to_q15(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 16384) >>> 15;
        if (m > 32767) begin
            m = 32767;
        end
        return (v < 0) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
    endfunction

    function automatic rom_t cos_rom(int points);
        rom_t  tbl;
        trig_t t;
        tbl = '0;
        for (int p = 0; p < points; p++) begin
            t = trig30(longint'(p), longint'(points));
            tbl[p*SAMPLE_W +: SAMPLE_W] = to_q15(t.co);
        end
        return tbl;
    endfunction

    function automatic rom_t sin_rom(int points);
        rom_t  tbl;
        trig_t t;
        tbl = '0;
        for (int p = 0; p < points; p++) begin
            t = trig30(longint'(p), longint'(points));
            tbl[p*SAMPLE_W +: SAMPLE_W] = to_q15(t.si);
        end
        return tbl;
    endfunction

    function automatic rom_t hann_rom(int points);
        rom_t  tbl;
        trig_t t;
        tbl = '0;
        for (int p = 0; p < points; p++) begin
            t = trig30(longint'(p), longint'(points - 1));
            tbl[p*SAMPLE_W +: SAMPLE_W] = to_q15((ONE_Q30 - t.co) / 2);
        end
        return tbl;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wdft_cell.sv
// One bin cell: accumulates its bin from passing samples and shifts results out.
`default_nettype none
module wdft_cell
    import wdft_pkg::*;
#(
    parameter int POINTS = 64
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cell_bus_t                         bus_in,
    output cell_bus_t                              bus_out,
    input  wire logic                              shift,
    input  wire logic signed [18+$clog2(POINTS)-1:0] shift_re,
    input  wire logic signed [18+$clog2(POINTS)-1:0] shift_im,
    output logic signed [18+$clog2(POINTS)-1:0]    acc_re,
    output logic signed [18+$clog2(POINTS)-1:0]    acc_im
);

    localparam int   ACC_W   = 18 + $clog2(POINTS);
    localparam rom_t COS_TBL = cos_rom(POINTS);
    localparam rom_t SIN_TBL = sin_rom(POINTS);

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [IDX_W-1:0]           n_reg;
    logic [IDX_W-1:0]           m_reg;
    logic [IDX_W-1:0]           m_next;
    logic [IDX_W:0]             m_sum;
    logic signed [ACC_W-1:0]    re_reg;
    logic signed [ACC_W-1:0]    im_reg;
    logic signed [ACC_W-1:0]    re_next;
    logic signed [ACC_W-1:0]    im_next;
    logic signed [SAMPLE_W-1:0] cos_w;
    logic signed [SAMPLE_W-1:0] sin_w;
    logic signed [31:0]         re_prod;
    logic signed [31:0]         im_prod;
    logic signed [32:0]         re_rnd;
    logic signed [32:0]         im_rnd;
    logic signed [ACC_W-1:0]    re_term;
    logic signed [ACC_W-1:0]    im_term;

    always_comb
    begin
        cos_w   = COS_TBL[bus_in.m*SAMPLE_W +: SAMPLE_W];
        sin_w   = SIN_TBL[bus_in.m*SAMPLE_W +: SAMPLE_W];
        re_prod = bus_in.x * cos_w;
        im_prod = bus_in.x * sin_w;
        re_rnd  = {re_prod[31], re_prod} + 33'sd16384;
        im_rnd  = -{im_prod[31], im_prod} + 33'sd16384;
        re_term = {{(ACC_W-18){re_rnd[32]}}, re_rnd[32:15]};
        im_term = {{(ACC_W-18){im_rnd[32]}}, im_rnd[32:15]};
        m_sum   = {1'b0, bus_in.m} + {1'b0, bus_in.n};
        if (m_sum >= (IDX_W+1)'(POINTS))
        begin
            m_next = IDX_W'(m_sum - (IDX_W+1)'(POINTS));
        end
        else
        begin
            m_next = m_sum[IDX_W-1:0];
        end
        if (bus_in.valid)
        begin
            re_next = (bus_in.n == '0) ? re_term : re_reg + re_term;
            im_next = (bus_in.n == '0) ? im_term : im_reg + im_term;
        end
        else if (shift)
        begin
            re_next = shift_re;
            im_next = shift_im;
        end
        else
        begin
            re_next = re_reg;
            im_next = im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= bus_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= bus_in.x;
        n_reg  <= bus_in.n;
        m_reg  <= m_next;
        re_reg <= re_next;
        im_reg <= im_next;
    end

    assign bus_out = '{valid: valid_reg, x: x_reg, n: n_reg, m: m_reg};
    assign acc_re  = re_reg;
    assign acc_im  = im_reg;

endmodule
`default_nettype wire

// File: hw/rtl/windowed_dft.sv
// Top level of the windowed DFT: sample store, window stage, bin cell chain and result output.
//
//   channel   signals                             transfer
//   input     start, busy, sample                 start high and busy low
//   config    window_mode_we, window_mode         window_mode_we high
//   result    bin_valid, bin_index, bin_real,     bin_valid high, one result per cycle
//             bin_imag, last_bin
//
// Samples load at one per cycle while start is high and busy is low. After the last sample
// of a frame the block is busy while it reads the POINTS samples from the sample store, passes
// them through two pipeline stages and the chain of POINTS bin cells and shifts the POINTS
// results out of the chain. The last result is valid in the same cycle that busy falls.
// Reset clears the control state and selects the rectangular window.
// Results come out at one per cycle and are never held back.
`default_nettype none
module windowed_dft
    import wdft_pkg::*;
#(
    parameter int POINTS = 64
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       window_mode_we,
    input  wire logic                       window_mode,
    output logic                            bin_valid,
    output logic [IDX_W-1:0]                bin_index,
    output logic signed [BIN_W-1:0]         bin_real,
    output logic signed [BIN_W-1:0]         bin_imag,
    output logic                            last_bin
);

    localparam int   ACC_W    = 18 + $clog2(POINTS);
    localparam rom_t HANN_TBL = hann_rom(POINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_FEED  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       window_mode_reg;
    logic [IDX_W-1:0]           load_cnt_reg;
    logic [IDX_W-1:0]           rd_cnt_reg;
    logic [IDX_W-1:0]           emit_cnt_reg;
    logic signed [SAMPLE_W-1:0] store [POINTS];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       v1_reg;
    logic [IDX_W-1:0]           n1_reg;
    logic                       v2_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic [IDX_W-1:0]           n2_reg;
    logic signed [SAMPLE_W-1:0] win_w;
    logic signed [31:0]         win_prod;
    logic signed [31:0]         win_rnd;
    logic signed [SAMPLE_W-1:0] xw;
    logic                       accept;
    logic                       feeding;
    logic                       shift;
    cell_bus_t                  bus [POINTS+1];
    logic signed [ACC_W-1:0]    acc_re [POINTS+1];
    logic signed [ACC_W-1:0]    acc_im [POINTS+1];

    assign busy    = (state_reg != S_LOAD);
    assign accept  = start && !busy;
    assign feeding = (state_reg == S_FEED);
    assign shift   = (state_reg == S_EMIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && load_cnt_reg == LAST_IDX)
                begin
                    state_next = S_FEED;
                end
            end
            S_FEED:
            begin
                if (rd_cnt_reg == LAST_IDX)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (bus[POINTS].valid && bus[POINTS].n == LAST_IDX)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_cnt_reg == LAST_IDX)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            window_mode_reg <= 1'b0;
            load_cnt_reg    <= '0;
            rd_cnt_reg      <= '0;
            emit_cnt_reg    <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            bin_valid       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= feeding;
            v2_reg    <= v1_reg;
            bin_valid <= shift;
            if (window_mode_we)
            begin
                window_mode_reg <= window_mode;
            end
            if (accept)
            begin
                load_cnt_reg <= (load_cnt_reg == LAST_IDX) ? '0 : load_cnt_reg + 1'b1;
            end
            if (feeding)
            begin
                rd_cnt_reg <= (rd_cnt_reg == LAST_IDX) ? '0 : rd_cnt_reg + 1'b1;
            end
            if (shift)
            begin
                emit_cnt_reg <= (emit_cnt_reg == LAST_IDX) ? '0 : emit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store[load_cnt_reg[$clog2(POINTS)-1:0]] <= sample;
        end
        rd_data_reg <= store[rd_cnt_reg[$clog2(POINTS)-1:0]];
    end

    always_comb
    begin
        win_w    = HANN_TBL[n1_reg*SAMPLE_W +: SAMPLE_W];
        win_prod = rd_data_reg * win_w;
        win_rnd  = win_prod + 32'sd16384;
        xw       = window_mode_reg ? win_rnd[30:15] : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        n1_reg <= rd_cnt_reg;
        x2_reg <= xw;
        n2_reg <= n1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            bin_index <= emit_cnt_reg;
            last_bin  <= (emit_cnt_reg == LAST_IDX);
            bin_real  <= {{(BIN_W-ACC_W){acc_re[0][ACC_W-1]}}, acc_re[0]};
            bin_imag  <= {{(BIN_W-ACC_W){acc_im[0][ACC_W-1]}}, acc_im[0]};
        end
    end

    assign bus[0]         = '{valid: v2_reg, x: x2_reg, n: n2_reg, m: '0};
    assign acc_re[POINTS] = '0;
    assign acc_im[POINTS] = '0;

    for (genvar k = 0; k < POINTS; k++)
    begin : g_cell
        wdft_cell #(
            .POINTS (POINTS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bus_in   (bus[k]),
            .bus_out  (bus[k+1]),
            .shift    (shift),
            .shift_re (acc_re[k+1]),
            .shift_im (acc_im[k+1]),
            .acc_re   (acc_re[k]),
            .acc_im   (acc_im[k])
        );
    end

endmodule
`default_nettype wire

// File: tb/windowed_dft_tb.sv
// Self-checking testbench of the windowed DFT: directed and random frames against a predictor.
module windowed_dft_tb
    import wdft_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int DRAIN_CYCLES = 3 * NPTS + 20;

    typedef struct {
        logic [IDX_W-1:0]        k;
        logic signed [BIN_W-1:0] re;
        logic signed [BIN_W-1:0] im;
        logic                    last;
    } bin_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic window_mode_we = 1'b0;
    logic window_mode = 1'b0;
    logic busy;
    logic bin_valid;
    logic [IDX_W-1:0] bin_index;
    logic signed [BIN_W-1:0] bin_real;
    logic signed [BIN_W-1:0] bin_imag;
    logic last_bin;

    windowed_dft #(.POINTS(NPTS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .window_mode_we(window_mode_we), .window_mode(window_mode),
        .bin_valid(bin_valid), .bin_index(bin_index), .bin_real(bin_real),
        .bin_imag(bin_imag), .last_bin(last_bin)
    );

    always #6 clk = ~clk;

    bin_t expected_bins[$];
    logic signed [SAMPLE_W-1:0] frame_buf[NPTS];
    int   fill_count = 0;
    logic hann_sel = 1'b0;
    int   errors = 0;
    logic signed [SAMPLE_W-1:0] cos_tab[NPTS];
    logic signed [SAMPLE_W-1:0] sin_tab[NPTS];
    logic signed [SAMPLE_W-1:0] hann_tab[NPTS];

    // Independent Q30 series evaluation of cos and sin of 2*pi*p/q.
    task automatic series_trig(input longint p0, input longint q,
                               output longint co, output longint si);
        longint p, quad, r, a, a2, ts, tc, s, c, sm, cm;
        p = p0 % q;
        quad = (4 * p) / q;
        r = (4 * p) % q;
        a = (r * 64'sd3373259426) / (2 * q);
        a2 = (a * a) >>> 30;
        s = a;
        ts = a;
        c = 64'sd1 << 30;
        tc = c;
        for (int j = 1; j <= 12; j++)
        begin
            ts = ((ts * a2) >>> 30) / ((2 * j) * (2 * j + 1));
            tc = ((tc * a2) >>> 30) / ((2 * j - 1) * (2 * j));
            if (j % 2 == 1)
            begin
                s -= ts;
                c -= tc;
            end
            else
            begin
                s += ts;
                c += tc;
            end
        end
        sm = s < 0 ? 0 : (s > (64'sd1 << 30) ? (64'sd1 << 30) : s);
        cm = c < 0 ? 0 : (c > (64'sd1 << 30) ? (64'sd1 << 30) : c);
        case (quad)
            0: begin si = sm; co = cm; end
            1: begin si = cm; co = -sm; end
            2: begin si = -sm; co = -cm; end
            default: begin si = -cm; co = sm; end
        endcase
    endtask

    function automatic logic signed [SAMPLE_W-1:0] q30_to_q15(longint v);
        longint mag;
        mag = v < 0 ? -v : v;
        mag = (mag + 16384) >>> 15;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        return v < 0 ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    function automatic longint mul_round(longint p);
        return (p + 16384) >>> 15;
    endfunction

    function automatic logic signed [BIN_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return BIN_W'(v);
    endfunction

    task automatic build_tables();
        longint co, si;
        for (int n = 0; n < NPTS; n++)
        begin
            series_trig(n, NPTS, co, si);
            cos_tab[n] = q30_to_q15(co);
            sin_tab[n] = q30_to_q15(si);
            series_trig(n, NPTS - 1, co, si);
            hann_tab[n] = q30_to_q15(((64'sd1 << 30) - co) / 2);
        end
    endtask

    task automatic compute_spectrum();
        longint xw[NPTS];
        longint re, im;
        bin_t b;
        for (int n = 0; n < NPTS; n++)
        begin
            xw[n] = hann_sel ? mul_round(longint'(frame_buf[n]) * hann_tab[n])
                             : longint'(frame_buf[n]);
        end
        for (int k = 0; k < NPTS; k++)
        begin
            re = 0;
            im = 0;
            for (int n = 0; n < NPTS; n++)
            begin
                re += mul_round(xw[n] * cos_tab[(k * n) % NPTS]);
                im += mul_round(-xw[n] * sin_tab[(k * n) % NPTS]);
            end
            b.k = IDX_W'(k);
            b.re = clip32(re);
            b.im = clip32(im);
            b.last = (k == NPTS - 1);
            expected_bins = {expected_bins, b};
        end
    endtask

    task automatic record_sample(input logic signed [SAMPLE_W-1:0] x);
        frame_buf[fill_count] = x;
        fill_count++;
        if (fill_count == NPTS)
        begin
            fill_count = 0;
            compute_spectrum();
        end
    endtask

    always @(posedge clk)
    begin
        bin_t e;
        if (rst_n && bin_valid)
        begin
            if (expected_bins.size() == 0)
            begin
                $display("%0t: unexpected bin k=%0d re=%0d im=%0d", $time, bin_index,
                         bin_real, bin_imag);
                errors++;
            end
            else
            begin
                e = expected_bins.pop_front();
                if (bin_index !== e.k || bin_real !== e.re || bin_imag !== e.im
                    || last_bin !== e.last)
                begin
                    $display("%0t: bin mismatch expected k=%0d re=%0d im=%0d last=%0d", $time,
                             e.k, e.re, e.im, e.last);
                    $display("%0t:              actual   k=%0d re=%0d im=%0d last=%0d", $time,
                             bin_index, bin_real, bin_imag, last_bin);
                    errors++;
                end
            end
        end
    end

    logic allow_gaps = 1'b1;

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
        int gap;
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        sample <= x;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        record_sample(x);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic hann);
        window_mode_we <= 1'b1;
        window_mode <= hann;
        @(posedge clk);
        window_mode_we <= 1'b0;
        hann_sel = hann;
    endtask

    // Directed frame: extremes, near-zero values and sign changes.
    logic signed [SAMPLE_W-1:0] directed_rows[] = '{
        16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff,
        16'sh5555, 16'shaaaa, 16'sh4000, 16'shc000, 16'sh7fff,
        16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0100, 16'sh00ff,
        16'sh1234, 16'shedcb, 16'sh7ffe, 16'sh8001, 16'sh0002,
        16'sh3fff, 16'shc001, 16'sh0000, 16'sh7fff
    };

    initial
    begin
        int kind;
        logic signed [SAMPLE_W-1:0] x;
        build_tables();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Rectangular frame of directed rows, padded with full-scale positive samples.
        for (int n = 0; n < NPTS; n++)
        begin
            send_sample(n < directed_rows.size() ? directed_rows[n] : 16'sh7fff);
        end
        wait_idle();
        set_window(1'b1);
        // Hann frame of random samples; its tail arrives with no idle cycles.
        for (int n = 0; n < NPTS; n++)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                1: x = SAMPLE_W'($urandom_range(0, 255)) - 16'sd128;
                default: x = SAMPLE_W'($urandom());
            endcase
            if (n == NPTS - 16)
            begin
                allow_gaps = 1'b0;
            end
            send_sample(x);
        end
        wait_idle();
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
